### src/lcdx_pkg.sv
// ----------------------------------------------------------------------------
// lcdx_pkg
// Types, codes and constants shared by the LCD expander byte sequencer.
// ----------------------------------------------------------------------------
package lcdx_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_COMMAND = 2'd0;
  localparam logic [1:0] FUNC_CHAR    = 2'd1;
  localparam logic [1:0] FUNC_GOTO    = 2'd2;

  // Register map: byte addresses
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DEVICE_ADDRESS = 3'd0;
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h27;

  // Expander pin bits
  localparam logic [7:0] PIN_BACKLIGHT = 8'h08;
  localparam logic [7:0] PIN_ENABLE    = 8'h04;
  localparam logic [7:0] PIN_RS        = 8'h01;

  // Display commands and cursor geometry
  localparam logic [7:0] CMD_HOME  = 8'h80;
  localparam logic [7:0] CMD_LINE1 = 8'hC0;
  localparam logic [5:0] LINE_CHARS   = 6'd16;
  localparam logic [5:0] SCREEN_CHARS = 6'd32;
  localparam logic [4:0] CURSOR_LINE1 = 5'd16;

  // Byte positions inside one transaction
  localparam logic [2:0] IDX_ADDR    = 3'd0;
  localparam logic [2:0] IDX_HI_EN   = 3'd1;
  localparam logic [2:0] IDX_HI      = 3'd2;
  localparam logic [2:0] IDX_LO_EN   = 3'd3;
  localparam logic [2:0] IDX_LO      = 3'd4;
  localparam logic [3:0] TXN_BYTES   = 4'd5;
  localparam logic [3:0] STEP_LAST_ONE = 4'd4;
  localparam logic [3:0] STEP_LAST_TWO = 4'd9;

  // Job queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] value;
    logic       line;
    logic [3:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } out_item_t;

  // One classified item: a first transaction and an optional follow-up command
  typedef struct packed {
    logic [7:0] first_byte;
    logic       first_data;
    logic       two;
    logic [7:0] second_byte;
  } job_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

endpackage

### src/char_lcd_expander_byte_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_expander_byte_sequencer
// LCD commands, characters and cursor moves to I2C bytes for a 4-bit LCD.
// ----------------------------------------------------------------------------
// The first byte of an item passes through the job queue, then the output register.
// Each item gives 5 bytes, 10 when a line or screen wrap follows a
//   character; the back sequencer emits one byte per cycle while out_stall is low.
// Items are taken while the job queue has room (default four jobs).
// Reset: cursor counter 0, device address 0x27, queue and output empty.
// ----------------------------------------------------------------------------
module char_lcd_expander_byte_sequencer #(
  parameter int unsigned QueueDepth = lcdx_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lcdx_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lcdx_pkg::out_item_t                out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcdx_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import lcdx_pkg::*;

  logic [6:0] device_address;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  q_status_t  q_status;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DEVICE_ADDRESS) ? {25'd0, device_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_DEVICE_ADDRESS) begin
      device_address <= pwdata[6:0];
    end
  end

  lcdx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  lcdx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  lcdx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

  // No job is queued while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  // A job is retired only when one is held
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.head_valid)
    else $error("job retired from empty queue");

  // The closing byte of an item always ends a bus transaction
  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last) |-> out_item.stop_after)
    else $error("last byte without stop");

  // A retired job puts a valid byte on the output next cycle
  a_pop_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && out_item.last))
    else $error("retired job did not present its last byte");

endmodule

### src/lcdx_queue.sv
// ----------------------------------------------------------------------------
// lcdx_queue
// Short job queue between the classifying front and the byte sequencer.
// ----------------------------------------------------------------------------
module lcdx_queue #(
  parameter int unsigned Depth = lcdx_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdx_pkg::job_t     push_job,
  input  logic               pop,
  output lcdx_pkg::job_t     head,
  output lcdx_pkg::q_status_t status
);
  import lcdx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  // Store new job at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head              = entries[rd_ptr];
  assign status.full       = (count == CntFull);
  assign status.head_valid = (count != '0);

endmodule

### src/lcdx_front.sv
// ----------------------------------------------------------------------------
// lcdx_front
// Accepts input transactions, classifies them and tracks the cursor counter.
// ----------------------------------------------------------------------------
module lcdx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdx_pkg::in_item_t  in_item,
  input  lcdx_pkg::q_status_t q_status,
  output logic                push,
  output lcdx_pkg::job_t      push_job
);
  import lcdx_pkg::*;

  logic [4:0] cursor;
  logic [4:0] cursor_next;
  logic [5:0] cursor_inc;
  logic       accept;
  logic       known;

  assign in_stall   = q_status.full;
  assign accept     = in_valid && !in_stall;
  assign cursor_inc = {1'b0, cursor} + 6'd1;

  // Classify the item into one or two transactions
  always_comb begin
    known                = 1'b1;
    cursor_next          = cursor;
    push_job.first_byte  = in_item.value;
    push_job.first_data  = 1'b0;
    push_job.two         = 1'b0;
    push_job.second_byte = CMD_HOME;
    unique case (in_item.func)
      FUNC_COMMAND: begin
      end
      FUNC_CHAR: begin
        push_job.first_data = 1'b1;
        if (cursor_inc == LINE_CHARS) begin
          push_job.two         = 1'b1;
          push_job.second_byte = CMD_LINE1;
          cursor_next          = CURSOR_LINE1;
        end else if (cursor_inc == SCREEN_CHARS) begin
          push_job.two         = 1'b1;
          push_job.second_byte = CMD_HOME;
          cursor_next          = '0;
        end else begin
          cursor_next = cursor_inc[4:0];
        end
      end
      FUNC_GOTO: begin
        push_job.first_byte = CMD_HOME | {1'b0, in_item.line, 2'b00, in_item.column};
        cursor_next         = {in_item.line, in_item.column};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Drop unused codes; queue everything else
  assign push = accept && known;

  // Hold cursor until a transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (push) begin
      cursor <= cursor_next;
    end
  end

endmodule

### src/lcdx_back.sv
// ----------------------------------------------------------------------------
// lcdx_back
// Byte sequencer: turns queued jobs into I2C bytes, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lcdx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [6:0]          device_address,
  input  lcdx_pkg::job_t      head,
  input  lcdx_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdx_pkg::out_item_t out_item
);
  import lcdx_pkg::*;

  logic [3:0] step;
  logic [3:0] idx_wide;
  logic [2:0] idx;
  logic       second_half;
  logic [7:0] cmd;
  logic [7:0] mode;
  logic [7:0] hi;
  logic [7:0] lo;
  logic       final_step;
  logic       advance;
  logic       load;
  out_item_t  item_next;

  assign advance     = !out_valid || !out_stall;
  assign load        = advance && q_status.head_valid;
  assign second_half = (step >= TXN_BYTES);
  assign idx_wide    = second_half ? step - TXN_BYTES : step;
  assign idx         = idx_wide[2:0];
  assign cmd         = second_half ? head.second_byte : head.first_byte;
  assign mode        = PIN_BACKLIGHT | ((!second_half && head.first_data) ? PIN_RS : 8'h00);
  assign hi          = {cmd[7:4], 4'b0000};
  assign lo          = {cmd[3:0], 4'b0000};
  assign final_step  = (step == STEP_LAST_TWO) || (step == STEP_LAST_ONE && !head.two);
  assign pop         = load && final_step;

  // Pick the byte for this step
  always_comb begin
    case (idx)
      IDX_ADDR:  item_next.bus_byte = {device_address, 1'b0};
      IDX_HI_EN: item_next.bus_byte = hi | mode | PIN_ENABLE;
      IDX_HI:    item_next.bus_byte = hi | mode;
      IDX_LO_EN: item_next.bus_byte = lo | mode | PIN_ENABLE;
      default:   item_next.bus_byte = lo | mode;
    endcase
    item_next.start_before = (idx == IDX_ADDR);
    item_next.stop_after   = (idx == IDX_LO);
    item_next.last         = final_step;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load) begin
      step <= final_step ? '0 : step + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_status.head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

### tb/char_lcd_expander_byte_sequencer_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_expander_byte_sequencer_tb
// Self-checking bench for the LCD expander byte sequencer.
// Drives LCD commands, characters and cursor moves through the valid/stall
// input channel and works out the I2C byte stream that each one should
// produce. This includes the line and home wraps that the cursor counter
// triggers. Every output byte is compared against that stream. The phases
// use different expander addresses and different sender and receiver idling.
// ----------------------------------------------------------------------------
module char_lcd_expander_byte_sequencer_tb;
  import lcdx_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PER_PHASE = 115;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Pending commands, expected bus bytes and the bench copy of the block state
  in_item_t  lcd_cmd_q[$];
  out_item_t bus_byte_q[$];
  logic [6:0] dev_addr_model;
  logic [4:0] cursor_model;

  int  send_idle_pct;
  int  recv_stall_pct;
  int  mismatches;
  int  cycle_count;
  logic in_fire;

  char_lcd_expander_byte_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
             want_v);
    mismatches++;
  endtask

  // Queue the five bytes of one I2C transaction: address, then two nibbles
  // each strobed with enable high and then low
  function automatic void push_transfer(input logic [7:0] lcd_byte, input logic is_data,
                                        input logic ends_item);
    logic [7:0] mode;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] seq [5];
    out_item_t b;
    mode = PIN_BACKLIGHT | (is_data ? PIN_RS : 8'h00);
    hi = {lcd_byte[7:4], 4'h0};
    lo = {lcd_byte[3:0], 4'h0};
    seq[0] = {dev_addr_model, 1'b0};
    seq[1] = hi | mode | PIN_ENABLE;
    seq[2] = hi | mode;
    seq[3] = lo | mode | PIN_ENABLE;
    seq[4] = lo | mode;
    for (int i = 0; i < 5; i++) begin
      b.bus_byte = seq[i];
      b.start_before = (i == 0);
      b.stop_after = (i == 4);
      b.last = (i == 4) && ends_item;
      bus_byte_q.push_back(b);
    end
  endfunction

  // Work out the bytes for one accepted command and advance the cursor
  function automatic void predict_lcd_bytes(input in_item_t it);
    logic [5:0] next_pos;
    next_pos = {1'b0, cursor_model} + 6'd1;
    case (it.func)
      FUNC_COMMAND: push_transfer(it.value, 1'b0, 1'b1);
      FUNC_CHAR: begin
        if (next_pos == LINE_CHARS) begin
          push_transfer(it.value, 1'b1, 1'b0);
          push_transfer(CMD_LINE1, 1'b0, 1'b1);
          cursor_model = CURSOR_LINE1;
        end else if (next_pos == SCREEN_CHARS) begin
          push_transfer(it.value, 1'b1, 1'b0);
          push_transfer(CMD_HOME, 1'b0, 1'b1);
          cursor_model = '0;
        end else begin
          push_transfer(it.value, 1'b1, 1'b1);
          cursor_model = next_pos[4:0];
        end
      end
      FUNC_GOTO: begin
        push_transfer(CMD_HOME + {1'b0, it.line, 2'b00, it.column}, 1'b0, 1'b1);
        cursor_model = {it.line, it.column};
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] f, input logic [7:0] v,
                                       input logic ln, input logic [3:0] col);
    in_item_t it;
    it.func = f;
    it.value = v;
    it.line = ln;
    it.column = col;
    return it;
  endfunction

  // Mostly characters so the cursor wraps often; moves lean towards the line end
  function automatic in_item_t rand_lcd_item();
    in_item_t it;
    int pick;
    it.value = 8'($urandom_range(255));
    it.line = 1'($urandom_range(1));
    it.column = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.func = FUNC_CHAR;
    end else if (pick < 72) begin
      it.func = FUNC_COMMAND;
    end else if (pick < 92) begin
      it.func = FUNC_GOTO;
      if ($urandom_range(1) == 1) it.column = 4'(12 + $urandom_range(3));
    end else begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [6:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_DEVICE_ADDRESS;
    pwdata  <= {25'd0, wdata};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_device_address(input logic [6:0] addr);
    logic [31:0] rd;
    apb_access(1'b1, addr, rd);
    dev_addr_model = addr;
    apb_access(1'b0, 7'd0, rd);
    if (rd[6:0] !== dev_addr_model) report_mismatch("device_address readback", rd[6:0],
                                                    dev_addr_model);
  endtask

  // Hold until every command is taken and every byte has come out
  task automatic wait_drained();
    while (lcd_cmd_q.size() != 0 || in_valid || bus_byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) lcd_cmd_q.push_back(rand_lcd_item());
  endtask

  // Driver: present the next command at the falling edge once the last is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (lcd_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= lcd_cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    out_item_t want;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) predict_lcd_bytes(in_item);
    if (!rst && out_valid && !out_stall) begin
      if (bus_byte_q.size() == 0) begin
        report_mismatch("unexpected bus_byte", out_item.bus_byte, 0);
      end else begin
        want = bus_byte_q.pop_front();
        if (out_item.bus_byte !== want.bus_byte)
          report_mismatch("bus_byte", out_item.bus_byte, want.bus_byte);
        if (out_item.start_before !== want.start_before)
          report_mismatch("start_before", out_item.start_before, want.start_before);
        if (out_item.stop_after !== want.stop_after)
          report_mismatch("stop_after", out_item.stop_after, want.stop_after);
        if (out_item.last !== want.last)
          report_mismatch("last", out_item.last, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_expander_byte_sequencer test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_fire = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    dev_addr_model = DEVICE_ADDRESS_RESET;
    cursor_model = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset address readback
    apb_access(1'b0, 7'd0, rd);
    if (rd[6:0] !== dev_addr_model) report_mismatch("device_address reset", rd[6:0],
                                                    dev_addr_model);

    // Directed: byte extremes, every function, ignored code and both wraps
    lcd_cmd_q.push_back(mk_item(FUNC_COMMAND, 8'h00, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_COMMAND, 8'hFF, 1'b1, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_COMMAND, 8'hA5, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'h00, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'hFF, 1'b1, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'h5A, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_UNUSED, 8'hFF, 1'b1, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_GOTO, 8'hFF, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_GOTO, 8'h00, 1'b1, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_GOTO, 8'h00, 1'b1, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_GOTO, 8'h00, 1'b0, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'h41, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_GOTO, 8'h00, 1'b1, 4'd15));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'h42, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_UNUSED, 8'h00, 1'b0, 4'd0));
    lcd_cmd_q.push_back(mk_item(FUNC_CHAR, 8'h7E, 1'b1, 4'd3));
    wait_drained();

    // Phase: reset address, no idling
    queue_random(RANDOM_PER_PHASE - 16);
    wait_drained();

    // Phase: lowest address, sender mostly idle
    set_device_address(7'd0);
    send_idle_pct = 65;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // Phase: highest address, receiver mostly stalling
    set_device_address(7'd127);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // Phase: random address, light idling both sides, with a full drain midway
    set_device_address(7'($urandom_range(127)));
    send_idle_pct = 14;
    recv_stall_pct = 14;
    queue_random(RANDOM_PER_PHASE / 2);
    wait_drained();
    queue_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
    wait_drained();

    if (mismatches == 0) begin
      $display("char_lcd_expander_byte_sequencer test passed");
    end else begin
      $display("char_lcd_expander_byte_sequencer test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/lcdx_pkg.sv
src/lcdx_queue.sv
src/lcdx_front.sv
src/lcdx_back.sv
src/char_lcd_expander_byte_sequencer.sv
tb/char_lcd_expander_byte_sequencer_tb.sv
